// ----- hw/rtl/cascaded_fractional_moving_average_macros.svh -----
// Assertion macros for the cascaded fractional moving-average block.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef CASCADED_FRACTIONAL_MOVING_AVERAGE_MACROS_SVH
`define CASCADED_FRACTIONAL_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CFMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/cfma_pkg.sv -----
// Shared constants, types and arithmetic helpers of the moving-average block.
// No dependencies; the interfaces, the top level, the datapath and the controller import this package.
`timescale 1ns / 1ps
`default_nettype none
package cfma_pkg;

    localparam int SAMPLE_WIDTH  = 24;
    localparam int MAX_STAGES    = 11;
    localparam int DELAY_ROWS    = 11;
    localparam int MAX_USED_TAPS = 9;

    localparam int REG_WIDTH   = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int ROW_W       = 4;
    localparam int STAGE_W     = 4;
    localparam int ADDR_W      = ROW_W + STAGE_W;
    localparam int MEM_DEPTH   = MAX_STAGES * (1 << ROW_W);
    localparam int TOTAL_W     = 20;
    localparam int WEIGHT_W    = 18;
    localparam int COEF_W      = 19;
    localparam int ACC_W       = 46;
    localparam int DIV_N_W     = 33;
    localparam int DIV_CNT_W   = 6;
    localparam int DIV_STEPS   = DIV_N_W;

    localparam logic [CFG_IDX_W-1:0] CFG_TAP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WET  = 2'd2;

    localparam logic [REG_WIDTH-1:0] ONE_Q16 = 17'h10000;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

    typedef enum logic [1:0] {
        A_ROW,
        A_PREV,
        A_CUR,
        A_IN
    } a_sel_t;

    typedef enum logic [2:0] {
        C_WEIGHT,
        C_ONE_MINUS_BLEND,
        C_BLEND,
        C_WET,
        C_DRY
    } c_sel_t;

    typedef struct packed {
        logic              mem_clear;
        logic              row_step;
        logic [ADDR_W-1:0] addr;
        logic [ROW_W-1:0]  row;
        logic              load_in;
        logic              mac_en;
        a_sel_t            a_sel;
        c_sel_t            c_sel;
        logic              stage_end;
        logic              div_load;
        logic              div_last;
        logic              div_step;
        logic              wf_store;
        logic              wl_store;
        logic              out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [ROW_W-1:0]   used_taps;
        logic [STAGE_W-1:0] stages;
    } dp_status_t;

    function automatic logic [REG_WIDTH-1:0] clamp_reg(input logic [REG_WIDTH-1:0] v);
        logic [REG_WIDTH-1:0] r;
        begin
            r = (v[REG_WIDTH-1] && (v[REG_WIDTH-2:0] != '0)) ? ONE_Q16 : v;
            return r;
        end
    endfunction

    // Round half up by 16 bits, then saturate to the sample width.
    function automatic sample_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        logic signed [ACC_W-1:0] shifted;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        sample_t                 r;
        begin
            biased  = acc + ACC_W'(32768);
            shifted = biased >>> 16;
            hi      = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
            lo      = -(ACC_W'(64'sd1 <<< (SAMPLE_WIDTH - 1)));
            if (shifted > hi)
            begin
                r = hi[SAMPLE_WIDTH-1:0];
            end
            else if (shifted < lo)
            begin
                r = lo[SAMPLE_WIDTH-1:0];
            end
            else
            begin
                r = shifted[SAMPLE_WIDTH-1:0];
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/cfma_if.sv -----
// Valid/ready stream interfaces for the stereo sample and result channels.
// Depends on cfma_pkg for the sample type.
`timescale 1ns / 1ps
`default_nettype none
interface cfma_sample_if;
    import cfma_pkg::*;
    logic    valid;
    logic    ready;
    sample_t left_sample;
    sample_t right_sample;
    modport source (output valid, output left_sample, output right_sample, input ready);
    modport sink (input valid, input left_sample, input right_sample, output ready);
endinterface

interface cfma_result_if;
    import cfma_pkg::*;
    logic    valid;
    logic    ready;
    sample_t left_out;
    sample_t right_out;
    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/cascaded_fractional_moving_average.sv -----
// Top level of the stereo cascaded fractional moving-average filter.
// Depends on cfma_pkg, cfma_if, cfma_controller, cfma_datapath and the macro header.
//
// Usage:
//  - samples (sink): one stereo Q1.23 pair per transaction, valid/ready.
//  - results (source): one filtered, wet/dry mixed pair per input transaction.
//  - cfg_we/cfg_index/cfg_data: write tap_amount (0), pole_amount (1),
//    wet_amount (2); values above 1.0 are clamped. Write only while idle.
//  - One pair is processed at a time through a single stereo MAC and one
//    delay memory port, so the next pair is accepted once the current one
//    is in the output register.
//  - A tap_amount write recomputes the weights with a bit-serial divider;
//    samples ready is held low meanwhile and in the write cycle.
//  - Reset: the delay memory is cleared, then the default weights are
//    derived; samples ready stays low meanwhile.
//  - A stalled receiver keeps the result in the output register; the block
//    still takes and processes the next pair, then holds it until the
//    output register frees up.
`timescale 1ns / 1ps
`default_nettype none
`include "cascaded_fractional_moving_average_macros.svh"
module cascaded_fractional_moving_average (
    input  wire                           clk,
    input  wire                           rst_n,
    cfma_sample_if.sink                   samples,
    cfma_result_if.source                 results,
    input  wire                           cfg_we,
    input  wire [cfma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [cfma_pkg::REG_WIDTH-1:0] cfg_data
);
    import cfma_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;

    // Sequencer: owns the handshake, counters and states
    cfma_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .in_valid  (samples.valid),
        .out_ready (results.ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // Arithmetic, delay memory and configuration registers
    cfma_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_sample  (samples.left_sample),
        .right_sample (samples.right_sample),
        .cmd          (cmd),
        .status       (status),
        .left_out     (results.left_out),
        .right_out    (results.right_out)
    );

    assign samples.ready = in_ready;
    assign results.valid = out_valid;

    // The MAC is never busy while a new transaction can be taken.
    `CFMA_ASSERT_NOW(a_idle_no_mac, in_ready, !cmd.mac_en && !cmd.row_step, "MAC busy")
    // An accepted transaction starts processing: ready drops the next cycle.
    `CFMA_ASSERT_NEXT(a_busy_after_accept, samples.valid && in_ready, !in_ready, "ready held")
    // A result appears only after the output register was loaded.
    `CFMA_ASSERT_NOW(a_valid_from_load, $rose(out_valid), $past(cmd.out_load), "valid without load")

endmodule
`default_nettype wire

// ----- hw/rtl/cfma_datapath.sv -----
// Datapath: configuration registers, weight divider, delay memory, stereo MAC.
// Depends on cfma_pkg; driven by cfma_controller through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module cfma_datapath (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [cfma_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [cfma_pkg::REG_WIDTH-1:0]    cfg_data,
    input  cfma_pkg::sample_t                left_sample,
    input  cfma_pkg::sample_t                right_sample,
    input  cfma_pkg::dp_cmd_t                cmd,
    output cfma_pkg::dp_status_t             status,
    output cfma_pkg::sample_t                left_out,
    output cfma_pkg::sample_t                right_out
);
    import cfma_pkg::*;

    logic [REG_WIDTH-1:0] tap_reg, pole_reg, wet_reg;
    logic [WEIGHT_W-1:0]  wf_reg, wl_reg;
    logic [DIV_N_W-1:0]   div_n_reg;
    logic [TOTAL_W-1:0]   div_r_reg;
    sample_t in_l_reg, in_r_reg, cur_l_reg, cur_r_reg, prev_l_reg, prev_r_reg;
    sample_t out_l_reg, out_r_reg;
    logic signed [ACC_W-1:0] acc_l_reg, acc_r_reg;
    logic [2*SAMPLE_WIDTH-1:0] rdata_reg;
    logic [2*SAMPLE_WIDTH-1:0] mem [MEM_DEPTH];

    logic [TOTAL_W-1:0]   total, poles, total_m1;
    logic [ROW_W-1:0]     whole;
    logic [REG_WIDTH-1:0] remv;
    logic [ROW_W-1:0]     used;
    logic [DIV_N_W-1:0]   div_n_init;
    logic [TOTAL_W:0]     div_shift;
    logic                 div_ge;
    logic [2*SAMPLE_WIDTH-1:0] wdata;
    sample_t a_l, a_r;
    logic [WEIGHT_W-1:0]  weight;
    logic signed [COEF_W-1:0] coef;
    logic signed [ACC_W-1:0]  prod_l, prod_r;
    logic signed [COEF_W-1:0] wet_s;

    // Length and stage count in Q.16: 9*value + 1.0
    assign total    = TOTAL_W'({tap_reg, 3'b000}) + TOTAL_W'(tap_reg) + TOTAL_W'(ONE_Q16);
    assign poles    = TOTAL_W'({pole_reg, 3'b000}) + TOTAL_W'(pole_reg) + TOTAL_W'(ONE_Q16);
    assign total_m1 = total - TOTAL_W'(1);
    assign whole    = total_m1[TOTAL_W-1:16];
    assign remv     = REG_WIDTH'(total - {whole, 16'h0000});
    assign used     = (whole >= ROW_W'(MAX_USED_TAPS)) ? ROW_W'(MAX_USED_TAPS)
                                                       : whole + ROW_W'(1);

    always_comb
    begin
        status.used_taps = used;
        if (poles[TOTAL_W-1:16] >= STAGE_W'(MAX_STAGES))
        begin
            status.stages = STAGE_W'(MAX_STAGES);
        end
        else
        begin
            status.stages = poles[TOTAL_W-1:16] + STAGE_W'(1);
        end
    end

    // Divider: restoring, one quotient bit per step.
    assign div_n_init = (cmd.div_last ? {remv, 16'h0000} : {1'b1, 32'h0})
                        + DIV_N_W'(total[TOTAL_W-1:1]);
    assign div_shift  = {div_r_reg, div_n_reg[DIV_N_W-1]};
    assign div_ge     = (div_shift >= {1'b0, total});

    assign wdata = (cmd.row == '0) ? {cur_l_reg, cur_r_reg} : rdata_reg;

    always_comb
    begin
        if (cmd.row < whole)
        begin
            weight = wf_reg;
        end
        else if (cmd.row == whole)
        begin
            weight = wl_reg;
        end
        else
        begin
            weight = '0;
        end
    end

    assign wet_s = $signed({1'b0, wet_reg, 1'b0}) - $signed(COEF_W'(ONE_Q16));

    always_comb
    begin
        case (cmd.c_sel)
            C_WEIGHT:          coef = $signed({1'b0, weight});
            C_ONE_MINUS_BLEND: coef = $signed(COEF_W'(ONE_Q16) - COEF_W'(poles[15:0]));
            C_BLEND:           coef = $signed(COEF_W'(poles[15:0]));
            C_WET:             coef = wet_s;
            C_DRY:             coef = $signed(COEF_W'(ONE_Q16)) - wet_s;
            default:           coef = '0;
        endcase
        case (cmd.a_sel)
            A_ROW:
            begin
                a_l = wdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
                a_r = wdata[SAMPLE_WIDTH-1:0];
            end
            A_PREV:
            begin
                a_l = prev_l_reg;
                a_r = prev_r_reg;
            end
            A_CUR:
            begin
                a_l = cur_l_reg;
                a_r = cur_r_reg;
            end
            default:
            begin
                a_l = in_l_reg;
                a_r = in_r_reg;
            end
        endcase
    end

    assign prod_l = ACC_W'(a_l * coef);
    assign prod_r = ACC_W'(a_r * coef);

    // Configuration and weight registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg  <= '0;
            pole_reg <= '0;
            wet_reg  <= ONE_Q16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TAP:  tap_reg  <= clamp_reg(cfg_data);
                CFG_POLE: pole_reg <= clamp_reg(cfg_data);
                CFG_WET:  wet_reg  <= clamp_reg(cfg_data);
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            div_n_reg <= div_n_init;
            div_r_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_n_reg <= {div_n_reg[DIV_N_W-2:0], div_ge};
            div_r_reg <= div_ge ? TOTAL_W'(div_shift - {1'b0, total})
                                : div_shift[TOTAL_W-1:0];
        end
        if (cmd.wf_store)
        begin
            wf_reg <= div_n_reg[WEIGHT_W-1:0];
        end
        if (cmd.wl_store)
        begin
            wl_reg <= div_n_reg[WEIGHT_W-1:0];
        end
    end

    // Delay memory: read-first, one read and one write per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.mem_clear)
        begin
            mem[cmd.addr] <= '0;
        end
        else if (cmd.row_step)
        begin
            mem[cmd.addr] <= wdata;
        end
        if (cmd.row_step)
        begin
            rdata_reg <= mem[cmd.addr];
        end
    end

    // Sample registers and accumulators
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            in_l_reg  <= left_sample;
            in_r_reg  <= right_sample;
            cur_l_reg <= left_sample;
            cur_r_reg <= right_sample;
            acc_l_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (cmd.stage_end)
        begin
            prev_l_reg <= cur_l_reg;
            prev_r_reg <= cur_r_reg;
            cur_l_reg  <= round_sat(acc_l_reg);
            cur_r_reg  <= round_sat(acc_r_reg);
            acc_l_reg  <= '0;
            acc_r_reg  <= '0;
        end
        else if (cmd.mac_en)
        begin
            acc_l_reg <= acc_l_reg + prod_l;
            acc_r_reg <= acc_r_reg + prod_r;
        end
        if (cmd.out_load)
        begin
            out_l_reg <= cur_l_reg;
            out_r_reg <= cur_r_reg;
        end
    end

    assign left_out  = out_l_reg;
    assign right_out = out_r_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/cfma_controller.sv -----
// Controller: sequences memory clear, weight division, stage loop, blend and mix.
// Depends on cfma_pkg; drives cfma_datapath through dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none
module cfma_controller (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           cfg_we,
    input  wire [cfma_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire                           in_valid,
    input  wire                           out_ready,
    input  cfma_pkg::dp_status_t          status,
    output logic                          in_ready,
    output logic                          out_valid,
    output cfma_pkg::dp_cmd_t             cmd
);
    import cfma_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_DINIT = 4'd1;
    localparam logic [3:0] S_DIVF  = 4'd2;
    localparam logic [3:0] S_DIVL  = 4'd3;
    localparam logic [3:0] S_IDLE  = 4'd4;
    localparam logic [3:0] S_ROW   = 4'd5;
    localparam logic [3:0] S_SEND  = 4'd6;
    localparam logic [3:0] S_BL1   = 4'd7;
    localparam logic [3:0] S_BL2   = 4'd8;
    localparam logic [3:0] S_BLE   = 4'd9;
    localparam logic [3:0] S_MX1   = 4'd10;
    localparam logic [3:0] S_MX2   = 4'd11;
    localparam logic [3:0] S_MXE   = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]           state_reg, state_next;
    logic [STAGE_W-1:0]   stage_reg, stage_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [ADDR_W-1:0]    clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 tap_write;

    assign tap_write = cfg_we && (cfg_index == CFG_TAP);
    // a tap write takes precedence over a new transaction
    assign in_ready  = (state_reg == S_IDLE) && !tap_write;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        stage_next     = stage_reg;
        row_next       = row_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.addr       = {stage_reg, row_reg};
        cmd.row        = row_reg;
        cmd.a_sel      = A_ROW;
        cmd.c_sel      = C_WEIGHT;

        unique case (state_reg) inside
            S_CLEAR:
            begin
                cmd.mem_clear = 1'b1;
                cmd.addr      = clr_reg;
                clr_next      = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = S_DINIT;
                end
            end
            S_DINIT:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                // reload once more if the tap control changes now
                state_next   = tap_write ? S_DINIT : S_DIVF;
            end
            S_DIVF, S_DIVL:
            begin
                cmd.div_last = (state_reg == S_DIVL);
                if (tap_write)
                begin
                    state_next = S_DINIT;
                end
                else if (cnt_reg == DIV_CNT_W'(DIV_STEPS))
                begin
                    cnt_next = '0;
                    if (state_reg == S_DIVF)
                    begin
                        cmd.wf_store = 1'b1;
                        cmd.div_load = 1'b1;
                        cmd.div_last = 1'b1;
                        state_next   = S_DIVL;
                    end
                    else
                    begin
                        cmd.wl_store = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    cnt_next     = cnt_reg + DIV_CNT_W'(1);
                end
            end
            S_IDLE:
            begin
                if (tap_write)
                begin
                    state_next = S_DINIT;
                end
                else if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    stage_next  = '0;
                    row_next    = '0;
                    state_next  = S_ROW;
                end
            end
            S_ROW:
            begin
                // write row t, shift in the previous row, accumulate while t < used
                cmd.row_step = 1'b1;
                cmd.mac_en   = (row_reg < status.used_taps);
                row_next     = row_reg + ROW_W'(1);
                if (row_reg == status.used_taps + ROW_W'(1))
                begin
                    row_next   = '0;
                    state_next = S_SEND;
                end
            end
            S_SEND:
            begin
                cmd.stage_end = 1'b1;
                stage_next    = stage_reg + STAGE_W'(1);
                state_next    = (stage_reg == status.stages - STAGE_W'(1)) ? S_BL1 : S_ROW;
            end
            S_BL1:
            begin
                cmd.mac_en = 1'b1;
                cmd.a_sel  = A_PREV;
                cmd.c_sel  = C_ONE_MINUS_BLEND;
                state_next = S_BL2;
            end
            S_BL2:
            begin
                cmd.mac_en = 1'b1;
                cmd.a_sel  = A_CUR;
                cmd.c_sel  = C_BLEND;
                state_next = S_BLE;
            end
            S_MX1:
            begin
                cmd.mac_en = 1'b1;
                cmd.a_sel  = A_CUR;
                cmd.c_sel  = C_WET;
                state_next = S_MX2;
            end
            S_MX2:
            begin
                cmd.mac_en = 1'b1;
                cmd.a_sel  = A_IN;
                cmd.c_sel  = C_DRY;
                state_next = S_MXE;
            end
            S_BLE, S_MXE:
            begin
                cmd.stage_end = 1'b1;
                state_next    = (state_reg == S_BLE) ? S_MX1 : S_OUT;
            end
            S_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            stage_reg     <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire
